// ===== rtl/core/ps2mc_pkg.sv =====
`timescale 1ns / 1ps

package ps2mc_pkg;

  // Configuration register layout.
  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_LIMIT = 4'd0,
    REG_Y_LIMIT = 4'd1,
    REG_X_HOME  = 4'd2,
    REG_Y_HOME  = 4'd3
  } cfg_idx_e;

  localparam logic [CFG_BITS-1:0] X_LIMIT_RST = 12'd639;
  localparam logic [CFG_BITS-1:0] Y_LIMIT_RST = 12'd199;
  localparam logic [CFG_BITS-1:0] X_HOME_RST  = 12'd160;
  localparam logic [CFG_BITS-1:0] Y_HOME_RST  = 12'd100;

  // Bit positions inside the flags byte.
  localparam int BTN_LEFT_BIT   = 0;
  localparam int BTN_RIGHT_BIT  = 1;
  localparam int BTN_MIDDLE_BIT = 2;
  localparam int SYNC_BIT       = 3;
  localparam int X_SIGN_BIT     = 4;
  localparam int Y_SIGN_BIT     = 5;

  typedef enum logic [1:0] {
    PH_FLAGS  = 2'd0,
    PH_MOVE_X = 2'd1,
    PH_MOVE_Y = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CFG_BITS-1:0] x_limit;
    logic [CFG_BITS-1:0] y_limit;
    logic [CFG_BITS-1:0] x_home;
    logic [CFG_BITS-1:0] y_home;
    logic                load_x;
    logic                load_y;
  } cfg_t;

  typedef struct packed {
    logic       done;
    logic [7:0] flags;
    logic [7:0] move_x;
    logic [7:0] move_y;
  } frame_t;

endpackage

// ===== rtl/core/ps2mc_in_if.sv =====
`timescale 1ns / 1ps

interface ps2mc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       from_mouse;

  modport source (output valid, output rx_byte, output from_mouse, input ready);
  modport sink   (input valid, input rx_byte, input from_mouse, output ready);
endinterface

// ===== rtl/core/ps2mc_out_if.sv =====
`timescale 1ns / 1ps

interface ps2mc_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_pressed;
  logic                  right_pressed;
  logic                  middle_pressed;
  logic                  packet_done;

  modport source (
    output valid, output cursor_x, output cursor_y, output left_pressed,
    output right_pressed, output middle_pressed, output packet_done, input ready
  );
  modport sink (
    input valid, input cursor_x, input cursor_y, input left_pressed,
    input right_pressed, input middle_pressed, input packet_done, output ready
  );
endinterface

// ===== rtl/core/ps2mc_cfg_if.sv =====
`timescale 1ns / 1ps

interface ps2mc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ps2mc_cfg_regs.sv =====
`timescale 1ns / 1ps

module ps2mc_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  ps2mc_cfg_if.sink       cfg_ch,
  output ps2mc_pkg::cfg_t cfg
);
  import ps2mc_pkg::*;

  logic [CFG_BITS-1:0] x_limit_r, y_limit_r;
  logic                wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;

  // The home values take effect only by loading the cursor, so no copy is kept here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
    end else if (wr) begin
      unique case (cfg_ch.index)
        REG_X_LIMIT: x_limit_r <= cfg_ch.data;
        REG_Y_LIMIT: y_limit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.x_limit = x_limit_r;
    cfg.y_limit = y_limit_r;
    // A home write moves the cursor at once, so the written value is passed straight on.
    cfg.x_home  = cfg_ch.data;
    cfg.y_home  = cfg_ch.data;
    cfg.load_x  = wr && (cfg_ch.index == REG_X_HOME);
    cfg.load_y  = wr && (cfg_ch.index == REG_Y_HOME);
  end

endmodule

// ===== rtl/core/ps2mc_framer.sv =====
`timescale 1ns / 1ps

module ps2mc_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  input  logic              from_mouse,
  output ps2mc_pkg::frame_t frame
);
  import ps2mc_pkg::*;

  phase_e     phase_r, phase_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [7:0] move_x_r, move_x_nxt;
  logic       done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FLAGS;
      flags_r  <= '0;
      move_x_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      flags_r  <= flags_nxt;
      move_x_r <= move_x_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    move_x_nxt = move_x_r;
    done       = 1'b0;
    if (fire && from_mouse) begin
      unique case (phase_r)
        PH_MOVE_X: begin
          move_x_nxt = rx_byte;
          phase_nxt  = PH_MOVE_Y;
        end
        PH_MOVE_Y: begin
          done      = 1'b1;
          phase_nxt = PH_FLAGS;
        end
        default: begin
          // A flags byte must carry the always-one bit; otherwise it is dropped to resync.
          if (rx_byte[SYNC_BIT]) begin
            flags_nxt = rx_byte;
            phase_nxt = PH_MOVE_X;
          end else begin
            phase_nxt = PH_FLAGS;
          end
        end
      endcase
    end
  end

  always_comb begin
    frame.done   = done;
    frame.flags  = flags_r;
    frame.move_x = move_x_r;
    frame.move_y = rx_byte;
  end

endmodule

// ===== rtl/core/ps2mc_cursor.sv =====
`timescale 1ns / 1ps

module ps2mc_cursor #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ps2mc_pkg::frame_t     frame,
  input  ps2mc_pkg::cfg_t       cfg,
  output logic [COORD_BITS-1:0] pos_x_nxt,
  output logic [COORD_BITS-1:0] pos_y_nxt,
  output logic [2:0]            btn_nxt
);
  import ps2mc_pkg::*;

  localparam int CW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
  localparam logic [CW-1:0] COORD_MAX = CW'((1 << COORD_BITS) - 1);

  logic [COORD_BITS-1:0] pos_x_r, pos_y_r;
  logic [2:0]            btn_r;
  logic signed [8:0]     dx9, dy9;
  logic signed [CW-1:0]  sum_x, sum_y;

  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [CW-1:0] v,
    input logic [CFG_BITS-1:0]  limit
  );
    logic [CW-1:0] lim;
    logic [CW-1:0] hi;
    logic [CW-1:0] res;
    lim = CW'(limit);
    hi  = (lim > COORD_MAX) ? COORD_MAX : lim;
    if (v[CW-1]) begin
      res = '0;
    end else if ($unsigned(v) > hi) begin
      res = hi;
    end else begin
      res = $unsigned(v);
    end
    return res[COORD_BITS-1:0];
  endfunction

  assign dx9   = signed'({frame.flags[X_SIGN_BIT], frame.move_x});
  assign dy9   = signed'({frame.flags[Y_SIGN_BIT], frame.move_y});
  assign sum_x = signed'(CW'(pos_x_r)) + CW'(dx9);
  assign sum_y = signed'(CW'(pos_y_r)) - CW'(dy9);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    btn_nxt   = btn_r;
    if (frame.done) begin
      pos_x_nxt = clamp_coord(sum_x, cfg.x_limit);
      pos_y_nxt = clamp_coord(sum_y, cfg.y_limit);
      btn_nxt   = {frame.flags[BTN_MIDDLE_BIT], frame.flags[BTN_RIGHT_BIT],
                   frame.flags[BTN_LEFT_BIT]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= COORD_BITS'(X_HOME_RST);
      pos_y_r <= COORD_BITS'(Y_HOME_RST);
      btn_r   <= '0;
    end else begin
      pos_x_r <= cfg.load_x ? COORD_BITS'(cfg.x_home) : pos_x_nxt;
      pos_y_r <= cfg.load_y ? COORD_BITS'(cfg.y_home) : pos_y_nxt;
      btn_r   <= btn_nxt;
    end
  end

endmodule

// ===== rtl/core/ps2mc_out_skid.sv =====
`timescale 1ns / 1ps

module ps2mc_out_skid #(
  parameter int W = 28
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic         out_valid_r, skid_valid_r;
  logic [W-1:0] out_data_r, skid_data_r;
  logic         take;
  logic         drain;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign take      = in_valid && in_ready;
  assign drain     = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r && drain) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (take && drain) begin
        out_valid_r <= 1'b1;
      end else if (take) begin
        // Output is stalled; park the new request in the skid stage.
        skid_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r && drain) begin
      out_data_r <= skid_data_r;
    end else if (take && drain) begin
      out_data_r <= in_data;
    end
    if (take && !drain) begin
      skid_data_r <= in_data;
    end
  end

endmodule

// ===== rtl/core/ps2mc_if_files_note.sv =====
`timescale 1ns / 1ps

// Registered flag that marks a pending result; used to qualify checks at the top.
module ps2mc_busy_flag (
  input  logic clk,
  input  logic rst_n,
  input  logic set,
  input  logic clr,
  output logic busy
);
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (set) begin
      busy_r <= 1'b1;
    end else if (clr) begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
endmodule

// ===== rtl/core/ps2_mouse_packet_cursor_top.sv =====
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with a clamped cursor.
// in_ch carries one byte per request with a flag telling whether it came from
// the mouse port. Keyboard bytes leave all state alone. Mouse bytes are framed
// into flags / X / Y packets; a flags byte without its always-one bit is dropped.
// On the Y byte the cursor moves by the 9-bit signed deltas and is clamped to
// 0..limit, and the three buttons are latched.
// out_ch returns exactly one result per input request: cursor, buttons and a
// packet_done flag. The result is registered in the output stage; one byte per
// cycle is sustained while the receiver keeps out_ch.ready high.
// A two-entry output stage (output register plus skid register) absorbs a
// stalled receiver: in_ch.ready drops only when both hold a result.
// cfg_ch writes x_limit, y_limit, x_home, y_home (index 0..3, others ignored);
// a home write moves the cursor to that value at once. cfg_ch.ready is always high.
// Reset (rst_n low, synchronous) restores the register defaults, puts the cursor
// at home, releases the buttons and expects a flags byte.
module ps2_mouse_packet_cursor_top #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  ps2mc_in_if.sink    in_ch,
  ps2mc_out_if.source out_ch,
  ps2mc_cfg_if.sink   cfg_ch
);
  import ps2mc_pkg::*;

  localparam int RES_W = 2 * COORD_BITS + 4;
  localparam int CW    = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;

  cfg_t                  cfg;
  frame_t                frame;
  logic                  in_fire;
  logic                  in_ready;
  logic [COORD_BITS-1:0] pos_x_nxt, pos_y_nxt;
  logic [2:0]            btn_nxt;
  logic [RES_W-1:0]      res_data, out_data;
  logic                  pending;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  ps2mc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ps2mc_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .rx_byte    (in_ch.rx_byte),
    .from_mouse (in_ch.from_mouse),
    .frame      (frame)
  );

  ps2mc_cursor #(.COORD_BITS(COORD_BITS)) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .cfg       (cfg),
    .pos_x_nxt (pos_x_nxt),
    .pos_y_nxt (pos_y_nxt),
    .btn_nxt   (btn_nxt)
  );

  assign res_data = {pos_x_nxt, pos_y_nxt, btn_nxt, frame.done};

  ps2mc_out_skid #(.W(RES_W)) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_data   (res_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.cursor_x       = out_data[RES_W-1 -: COORD_BITS];
  assign out_ch.cursor_y       = out_data[COORD_BITS+3 -: COORD_BITS];
  assign out_ch.middle_pressed = out_data[3];
  assign out_ch.right_pressed  = out_data[2];
  assign out_ch.left_pressed   = out_data[1];
  assign out_ch.packet_done    = out_data[0];

  ps2mc_busy_flag u_pending (
    .clk   (clk),
    .rst_n (rst_n),
    .set   (in_fire),
    .clr   (out_ch.valid && out_ch.ready),
    .busy  (pending)
  );

  // After every accepted byte, out_ch.valid is high in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_ch.valid)
    else $error("accepted byte did not produce a result");

  // Input is held off only while a result is still waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_ch.valid && pending))
    else $error("input stalled with no pending result");

  // A completed packet never places the cursor past its bounds.
  a_clamp_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.packet_done) |->
      (CW'(out_ch.cursor_x) <= CW'(cfg.x_limit)))
    else $error("cursor x beyond limit");

  a_clamp_y: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.packet_done) |->
      (CW'(out_ch.cursor_y) <= CW'(cfg.y_limit)))
    else $error("cursor y beyond limit");

endmodule

// ===== bench/tb_ps2_mouse_packet_cursor_top.sv =====
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor_top;
  import ps2mc_pkg::*;

  localparam int COORD_BITS      = 12;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
  localparam int REG_COUNT       = 4;
  localparam int LAST_INDEX      = (1 << CFG_IDX_BITS) - 1;
  localparam int MAX_GAP         = 13;
  localparam int HOLD_OFF_CYCLES = 160;
  localparam int PRESSURE_PHASE  = 2;
  localparam int SETTING_COUNT   = 7;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int DRAIN_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam logic [CFG_BITS-1:0] REG_MAX = '1;

  typedef struct packed {
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  left_pressed;
    logic                  right_pressed;
    logic                  middle_pressed;
    logic                  packet_done;
  } cursor_report_t;

  class cursor_scoreboard;
    logic [CFG_BITS-1:0]   x_limit, y_limit, x_home, y_home;
    phase_e                byte_slot;
    logic [7:0]            flags;
    logic [7:0]            move_x;
    logic [COORD_BITS-1:0] pos_x, pos_y;
    logic [2:0]            buttons;
    cursor_report_t        expected_reports[$];
    int unsigned           errors;

    function new();
      x_limit   = X_LIMIT_RST;
      y_limit   = Y_LIMIT_RST;
      x_home    = X_HOME_RST;
      y_home    = Y_HOME_RST;
      byte_slot = PH_FLAGS;
      flags     = '0;
      move_x    = '0;
      pos_x     = X_HOME_RST;
      pos_y     = Y_HOME_RST;
      buttons   = '0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // A home write moves the cursor right away, without clamping it.
    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
      case (idx)
        REG_X_LIMIT: x_limit = value;
        REG_Y_LIMIT: y_limit = value;
        REG_X_HOME: begin
          x_home = value;
          pos_x  = value;
        end
        REG_Y_HOME: begin
          y_home = value;
          pos_y  = value;
        end
        default: ;
      endcase
    endfunction

    function logic [COORD_BITS-1:0] clamp_coord(int v, logic [CFG_BITS-1:0] limit);
      int hi;
      hi = int'(limit);
      if (hi > COORD_MAX) hi = COORD_MAX;
      if (v < 0) return '0;
      if (v > hi) return COORD_BITS'(hi);
      return COORD_BITS'(v);
    endfunction

    function void note_byte(logic [7:0] data, logic from_mouse);
      cursor_report_t   exp;
      logic signed [8:0] dx, dy;
      logic             done;
      done = 1'b0;
      if (from_mouse) begin
        case (byte_slot)
          PH_MOVE_X: begin
            move_x    = data;
            byte_slot = PH_MOVE_Y;
          end
          PH_MOVE_Y: begin
            dx        = {flags[X_SIGN_BIT], move_x};
            dy        = {flags[Y_SIGN_BIT], data};
            pos_x     = clamp_coord(int'(pos_x) + int'(dx), x_limit);
            pos_y     = clamp_coord(int'(pos_y) - int'(dy), y_limit);
            buttons   = {flags[BTN_MIDDLE_BIT], flags[BTN_RIGHT_BIT], flags[BTN_LEFT_BIT]};
            byte_slot = PH_FLAGS;
            done      = 1'b1;
          end
          default: begin
            // A flags byte without its sync bit is dropped to regain framing.
            if (data[SYNC_BIT]) begin
              flags     = data;
              byte_slot = PH_MOVE_X;
            end else begin
              byte_slot = PH_FLAGS;
            end
          end
        endcase
      end
      exp.cursor_x       = pos_x;
      exp.cursor_y       = pos_y;
      exp.left_pressed   = buttons[0];
      exp.right_pressed  = buttons[1];
      exp.middle_pressed = buttons[2];
      exp.packet_done    = done;
      expected_reports.push_back(exp);
    endfunction

    function void cmp_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_report(cursor_report_t act);
      cursor_report_t exp;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual x %0d y %0d",
                 $time, act.cursor_x, act.cursor_y);
        errors++;
        return;
      end
      exp = expected_reports.pop_front();
      cmp_field("cursor_x", exp.cursor_x, act.cursor_x);
      cmp_field("cursor_y", exp.cursor_y, act.cursor_y);
      cmp_field("left_pressed", exp.left_pressed, act.left_pressed);
      cmp_field("right_pressed", exp.right_pressed, act.right_pressed);
      cmp_field("middle_pressed", exp.middle_pressed, act.middle_pressed);
      cmp_field("packet_done", exp.packet_done, act.packet_done);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        src_calm;
  logic        snk_calm;
  logic        hold_off;
  int          phase_no;
  int unsigned cycles = 0;

  cursor_scoreboard board = new();

  ps2mc_in_if                              in_bus ();
  ps2mc_out_if #(.COORD_BITS(COORD_BITS))  out_bus ();
  ps2mc_cfg_if                             cfg_bus ();

  ps2_mouse_packet_cursor_top #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    cursor_report_t got;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.cursor_x       = out_bus.cursor_x;
        got.cursor_y       = out_bus.cursor_y;
        got.left_pressed   = out_bus.left_pressed;
        got.right_pressed  = out_bus.right_pressed;
        got.middle_pressed = out_bus.middle_pressed;
        got.packet_done    = out_bus.packet_done;
        board.check_report(got);
      end
      if (cfg_bus.valid && cfg_bus.ready) board.write_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) board.note_byte(in_bus.rx_byte, in_bus.from_mouse);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, board.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // Switches each side between stretches without idling and stretches with gaps.
  initial begin
    src_calm = 1'b0;
    snk_calm = 1'b0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      src_calm <= ($urandom_range(0, 3) == 0);
      snk_calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // Long receiver stall while the sender keeps offering, so the input backs up.
  initial begin
    hold_off = 1'b0;
    wait (phase_no == PRESSURE_PHASE);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : receiver
    int unsigned hold;
    int unsigned gap;
    out_bus.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_off) begin
        out_bus.ready <= 1'b0;
        hold = 0;
      end else if (out_bus.ready) begin
        if (out_bus.valid) begin
          gap = snk_calm ? 0 : $urandom_range(0, MAX_GAP);
          if (gap != 0) begin
            out_bus.ready <= 1'b0;
            hold = gap;
          end
        end
      end else begin
        if (hold <= 1) out_bus.ready <= 1'b1;
        else hold--;
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic from_mouse);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.rx_byte    <= data;
    in_bus.from_mouse <= from_mouse;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_mouse_packet(input logic [7:0] f, input logic [7:0] mx,
                                   input logic [7:0] my, input bit mixed);
    send_byte(f, 1'b1);
    if (mixed && $urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'b0);
    send_byte(mx, 1'b1);
    if (mixed && $urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'b0);
    send_byte(my, 1'b1);
  endtask

  // Favors the extreme moves now and then.
  function automatic logic [7:0] pick_move();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      3:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned kind;
    logic [7:0]  f;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      f = 8'($urandom);
      f[SYNC_BIT] = 1'b1;
      if (kind < 7) begin
        send_mouse_packet(f, pick_move(), pick_move(), 1'b1);
        sent += 3;
      end else if (kind == 7) begin
        send_byte(8'($urandom), 1'b0);
      end else if (kind == 8) begin
        send_byte(8'($urandom), 1'b1);
        sent++;
      end else begin
        // Packet cut short: the next mouse byte lands in the Y slot.
        send_byte(f, 1'b1);
        send_byte(pick_move(), 1'b1);
        sent += 2;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic load_settings(input logic [CFG_BITS-1:0] xl, input logic [CFG_BITS-1:0] yl,
                               input logic [CFG_BITS-1:0] xh, input logic [CFG_BITS-1:0] yh);
    write_reg(REG_X_LIMIT, xl);
    write_reg(REG_Y_LIMIT, yl);
    write_reg(CFG_IDX_BITS'($urandom_range(REG_COUNT, LAST_INDEX)), CFG_BITS'($urandom));
    write_reg(REG_X_HOME, xh);
    write_reg(REG_Y_HOME, yh);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.rx_byte    = '0;
    in_bus.from_mouse = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    phase_no          = -1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keyboard byte, flags candidates without the sync bit, then whole packets.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hF7, 1'b1);
    send_mouse_packet(8'h08, 8'h00, 8'h00, 1'b0);
    send_mouse_packet(8'h0F, 8'h7F, 8'hFF, 1'b0);
    send_mouse_packet(8'h38, 8'h00, 8'h00, 1'b0);
    send_mouse_packet(8'hC8, 8'hFF, 8'h01, 1'b0);
    send_mouse_packet(8'h1A, 8'h00, 8'h00, 1'b0);
    send_mouse_packet(8'h19, 8'h80, 8'h00, 1'b0);
    // Keyboard bytes in the middle of a packet leave the framing alone.
    send_byte(8'h09, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h10, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h10, 1'b1);
    in_bus.valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < SETTING_COUNT; p++) begin
      case (p)
        0: load_settings(REG_MAX, REG_MAX, '0, '0);
        1: load_settings('0, '0, '0, '0);
        2: load_settings(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        3: load_settings(12'd100, 12'd50, 12'd300, 12'd200);
        6: load_settings(X_LIMIT_RST, Y_LIMIT_RST, X_HOME_RST, Y_HOME_RST);
        default: load_settings(CFG_BITS'($urandom), CFG_BITS'($urandom),
                               CFG_BITS'($urandom), CFG_BITS'($urandom));
      endcase
      phase_no = p;
      run_random(ITEMS_PER_PHASE);
      in_bus.valid <= 1'b0;
      wait_idle();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
